/* rtl/obstacle_signed_distance_unit_defines.svh */
// Assertion macros shared by the obstacle signed distance RTL.
`ifndef OBSTACLE_SIGNED_DISTANCE_UNIT_DEFINES_SVH
`define OBSTACLE_SIGNED_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OSD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/osd_pkg.sv */
// Types, widths and codes for the obstacle signed distance unit.
`default_nettype none

package osd_pkg;

    localparam int AXES       = 3;
    localparam int COORD_W    = 20;
    localparam int TIME_W     = 16;
    localparam int QUAT_W     = 16;
    localparam int MARGIN_W   = 16;
    localparam int OUT_W      = 24;
    localparam int KIND_W     = 2;
    localparam int VEC_W      = AXES * COORD_W;
    localparam int ROT_W      = 4 * QUAT_W;
    localparam int TIME_FRAC  = 10;
    localparam int QUAT_FRAC  = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [ROT_W-1:0] ROT_RESET = ROT_W'(16384);

    // datapath widths
    localparam int VT_W    = COORD_W + TIME_W + 1;
    localparam int OFF_W   = VT_W - TIME_FRAC;
    localparam int DIFF_W  = 28;
    localparam int QN_W    = QUAT_W + 1;
    localparam int PA_W    = QN_W + DIFF_W;
    localparam int PE_W    = PA_W + 3;
    localparam int T_W     = 33;
    localparam int PB_W    = QN_W + T_W;
    localparam int RS_W    = PB_W + 2;
    localparam int RSH_W   = RS_W - QUAT_FRAC;
    localparam int SUM_W   = RSH_W + 1;
    localparam int LOC_W   = 29;
    localparam int LOC_MAX = 268435455;
    localparam int ABS_W   = LOC_W - 1;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int NMP_W   = COORD_W + 2;
    localparam int VP_W    = 30;
    localparam int D_W     = 32;
    localparam int DM_W    = D_W + 1;

    // square root unit
    localparam int SQ_IN_W  = 60;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_RND_W = SQ_OUT_W + 1;
    localparam int SQ_LAT   = SQ_OUT_W + 1;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND     = 3'd0,
        CFG_CENTER   = 3'd1,
        CFG_EXTENTS  = 3'd2,
        CFG_ROTATION = 3'd3,
        CFG_MARGIN   = 3'd4,
        CFG_MOVING   = 3'd5,
        CFG_VELOCITY = 3'd6
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        SHAPE_SPHERE   = 2'd0,
        SHAPE_BOX      = 2'd1,
        SHAPE_CYLINDER = 2'd2,
        SHAPE_OTHER    = 2'd3
    } t_shape;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic        [TIME_W-1:0]  time_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] signed_distance;
        logic                    inside_flag;
    } t_out_item;

    // carried alongside the first root
    typedef struct packed {
        logic                    in_box;
        logic signed [NMP_W-1:0] neg_mp;
        logic signed [VP_W-1:0]  vp;
    } t_side_a;

    // carried alongside the second root
    typedef struct packed {
        logic                  need2;
        logic signed [D_W-1:0] d_pre;
    } t_side_b;

endpackage

`default_nettype wire

/* rtl/osd_sqrt.sv */
// Pipelined rounded integer square root, one result bit per stage.
`default_nettype none

module osd_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [osd_pkg::SQ_IN_W-1:0]  i_rad,
    output logic [osd_pkg::SQ_RND_W-1:0] o_root
);
    import osd_pkg::*;

    logic [SQ_IN_W-1:0]  r_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_root [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  s_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] s_root [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  n_rem  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] n_root [SQ_OUT_W];
    logic [SQ_RND_W-1:0] r_res;

    always_comb begin
        s_rem[0]  = i_rad;
        s_root[0] = '0;
        for (int g = 1; g < SQ_OUT_W; g++) begin
            s_rem[g]  = r_rem[g-1];
            s_root[g] = r_root[g-1];
        end
    end

    // stage g decides root bit SQ_OUT_W-1-g
    always_comb begin
        logic [SQ_IN_W-1:0] trial;
        for (int g = 0; g < SQ_OUT_W; g++) begin
            trial = (SQ_IN_W'(s_root[g]) << (SQ_OUT_W - g))
                  | (SQ_IN_W'(1) << (2 * (SQ_OUT_W - 1 - g)));
            if (s_rem[g] >= trial) begin
                n_rem[g]  = s_rem[g] - trial;
                n_root[g] = s_root[g] | (SQ_OUT_W'(1) << (SQ_OUT_W - 1 - g));
            end else begin
                n_rem[g]  = s_rem[g];
                n_root[g] = s_root[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            // round up when the remainder passes the floor root
            if (r_rem[SQ_OUT_W-1] > SQ_IN_W'(r_root[SQ_OUT_W-1])) begin
                r_res <= SQ_RND_W'(r_root[SQ_OUT_W-1]) + SQ_RND_W'(1);
            end else begin
                r_res <= SQ_RND_W'(r_root[SQ_OUT_W-1]);
            end
        end
    end

    assign o_root = r_res;

endmodule

`default_nettype wire

/* rtl/obstacle_signed_distance_unit.sv */
// Structure: 13 arithmetic stages, two 31-stage square root pipelines and one output
// register lie between input acceptance and o_out_valid.
// Throughput: one item per cycle; an output register and a skid entry
// hold results, and the whole pipeline freezes only while the skid entry is full.
// Reset: synchronous active-low i_rst_n clears all valid bits and loads register
// defaults (rotation w = 1.0, all else zero). No clearing pass.
`default_nettype none
`include "obstacle_signed_distance_unit_defines.svh"

module obstacle_signed_distance_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  osd_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output osd_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [osd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [osd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import osd_pkg::*;

    // configuration
    t_shape                r_kind;
    logic [VEC_W-1:0]      r_center;
    logic [VEC_W-1:0]      r_ext;
    logic [ROT_W-1:0]      r_rot;
    logic [MARGIN_W-1:0]   r_margin;
    logic                  r_moving;
    logic [VEC_W-1:0]      r_vel;

    logic signed [COORD_W-1:0] w_cen [AXES];
    logic signed [COORD_W-1:0] w_vel [AXES];
    logic        [COORD_W-1:0] w_ext [AXES];
    logic        [COORD_W-1:0] w_extmax;
    logic signed [QUAT_W-1:0]  w_qw;
    logic signed [QN_W-1:0]    w_nq [AXES];
    logic signed [COORD_W-1:0] w_pt [AXES];

    logic w_adv;
    logic w_od_sign;

    // pipeline
    logic                     r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    logic                     r10_v, r11_v, r12_v, r13_v;
    logic signed [VT_W-1:0]   n1_vt [AXES], r1_vt [AXES];
    logic signed [COORD_W-1:0] r1_p [AXES];
    logic signed [DIFF_W-1:0] n2_diff [AXES], r2_diff [AXES], r3_diff [AXES];
    logic signed [DIFF_W-1:0] r4_diff [AXES], r5_diff [AXES], r6_diff [AXES];
    logic signed [PA_W-1:0]   n3_a [AXES], n3_b [AXES], r3_a [AXES], r3_b [AXES];
    logic signed [T_W-1:0]    n4_t [AXES], r4_t [AXES];
    logic signed [PB_W-1:0]   n5_w [AXES], n5_a [AXES], n5_b [AXES];
    logic signed [PB_W-1:0]   r5_w [AXES], r5_a [AXES], r5_b [AXES];
    logic signed [LOC_W-1:0]  n6_loc [AXES], r6_loc [AXES];
    logic        [ABS_W-1:0]  n7_mag [AXES], r7_mag [AXES];
    t_side_a                  n7_side, r7_side, r8_side, r9_side;
    logic        [SQ_W-1:0]   n8_sq [AXES], r8_sq [AXES];
    logic        [SQ_IN_W-1:0] r9_sum;

    logic                     r_va [SQ_LAT];
    t_side_a                  r_sa [SQ_LAT];
    logic [SQ_RND_W-1:0]      w_root_a;

    t_side_b                  n10_sb, r10_sb, r11_sb, r12_sb;
    logic [VP_W-1:0]          n10_h, n10_vv, r10_h, r10_vv;
    logic [SQ_IN_W-1:0]       r11_hsq, r11_vsq, r12_sum;

    logic                     r_vb [SQ_LAT];
    t_side_b                  r_sbd [SQ_LAT];
    logic [SQ_RND_W-1:0]      w_root_b;

    t_out_item                n13_d, r13_d;

    // output register and skid entry
    logic      r_ov, r_sv;
    t_out_item r_od, r_sd;

    assign w_adv       = !r_sv;
    assign o_in_stall  = r_sv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign w_od_sign   = r_od.signed_distance[OUT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= SHAPE_SPHERE;
            r_center <= '0;
            r_ext    <= '0;
            r_rot    <= ROT_RESET;
            r_margin <= '0;
            r_moving <= 1'b0;
            r_vel    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KIND:     r_kind   <= t_shape'(i_cfg_data[KIND_W-1:0]);
                CFG_CENTER:   r_center <= i_cfg_data[VEC_W-1:0];
                CFG_EXTENTS:  r_ext    <= i_cfg_data[VEC_W-1:0];
                CFG_ROTATION: r_rot    <= i_cfg_data[ROT_W-1:0];
                CFG_MARGIN:   r_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_MOVING:   r_moving <= i_cfg_data[0];
                CFG_VELOCITY: r_vel    <= i_cfg_data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_cen[i] = $signed(r_center[COORD_W*i +: COORD_W]);
            w_vel[i] = $signed(r_vel[COORD_W*i +: COORD_W]);
            w_ext[i] = r_ext[COORD_W*i +: COORD_W];
            // conjugate: negate the vector part
            w_nq[i]  = -QN_W'($signed(r_rot[QUAT_W*(i+1) +: QUAT_W]));
        end
        w_qw = $signed(r_rot[QUAT_W-1:0]);
        w_extmax = (w_ext[1] > w_ext[0]) ? w_ext[1] : w_ext[0];
        if (w_ext[2] > w_extmax) begin
            w_extmax = w_ext[2];
        end
        w_pt[0] = i_in_data.point_x;
        w_pt[1] = i_in_data.point_y;
        w_pt[2] = i_in_data.point_z;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v} <= '0;
            {r10_v, r11_v, r12_v, r13_v} <= '0;
            r_va <= '{default: 1'b0};
            r_vb <= '{default: 1'b0};
        end else if (w_adv) begin
            r1_v  <= i_in_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r_va[0] <= r9_v;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_va[k] <= r_va[k-1];
            end
            r10_v <= r_va[SQ_LAT-1];
            r11_v <= r10_v;
            r12_v <= r11_v;
            r_vb[0] <= r12_v;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_vb[k] <= r_vb[k-1];
            end
            r13_v <= r_vb[SQ_LAT-1];
        end
    end

    // stage 1: velocity times time
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n1_vt[i] = w_vel[i] * $signed({1'b0, i_in_data.time_offset});
        end
    end

    // stage 2: moved center and offset
    always_comb begin
        logic signed [VT_W-1:0]   rnd;
        logic signed [OFF_W-1:0]  off;
        logic signed [DIFF_W-1:0] ctr;
        for (int i = 0; i < AXES; i++) begin
            rnd = r1_vt[i] + $signed(VT_W'(1) << (TIME_FRAC - 1));
            off = $signed(rnd[VT_W-1:TIME_FRAC]);
            ctr = DIFF_W'(w_cen[i]) + (r_moving ? DIFF_W'(off) : DIFF_W'(0));
            n2_diff[i] = DIFF_W'(r1_p[i]) - ctr;
        end
    end

    // stage 3: first cross product terms
    always_comb begin
        n3_a[0] = w_nq[1] * r2_diff[2];
        n3_b[0] = w_nq[2] * r2_diff[1];
        n3_a[1] = w_nq[2] * r2_diff[0];
        n3_b[1] = w_nq[0] * r2_diff[2];
        n3_a[2] = w_nq[0] * r2_diff[1];
        n3_b[2] = w_nq[1] * r2_diff[0];
    end

    // stage 4: t = round(2 * cross / 2^14)
    always_comb begin
        logic signed [PE_W-1:0] e;
        for (int i = 0; i < AXES; i++) begin
            e = ((PE_W'(r3_a[i]) - PE_W'(r3_b[i])) <<< 1)
              + $signed(PE_W'(1) << (QUAT_FRAC - 1));
            n4_t[i] = $signed(e[QUAT_FRAC +: T_W]);
        end
    end

    // stage 5: second cross product and scalar terms
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n5_w[i] = w_qw * r4_t[i];
        end
        n5_a[0] = w_nq[1] * r4_t[2];
        n5_b[0] = w_nq[2] * r4_t[1];
        n5_a[1] = w_nq[2] * r4_t[0];
        n5_b[1] = w_nq[0] * r4_t[2];
        n5_a[2] = w_nq[0] * r4_t[1];
        n5_b[2] = w_nq[1] * r4_t[0];
    end

    // stage 6: local coordinates, saturated
    always_comb begin
        logic signed [RS_W-1:0]  r;
        logic signed [SUM_W-1:0] sum;
        for (int i = 0; i < AXES; i++) begin
            r = RS_W'(r5_w[i]) + RS_W'(r5_a[i]) - RS_W'(r5_b[i])
              + $signed(RS_W'(1) << (QUAT_FRAC - 1));
            sum = SUM_W'(r5_diff[i]) + SUM_W'($signed(r[QUAT_FRAC +: RSH_W]));
            if (sum > SUM_W'(LOC_MAX)) begin
                n6_loc[i] = LOC_W'(LOC_MAX);
            end else if (sum < SUM_W'(-LOC_MAX)) begin
                n6_loc[i] = LOC_W'(-LOC_MAX);
            end else begin
                n6_loc[i] = LOC_W'(sum);
            end
        end
    end

    // stage 7: vector to measure and per-shape side values
    always_comb begin
        logic [ABS_W-1:0]   absd [AXES];
        logic [ABS_W-1:0]   absl [AXES];
        logic [ABS_W-1:0]   gap  [AXES];
        logic [COORD_W-1:0] pen  [AXES];
        logic [COORD_W-1:0] mp;
        logic               over;
        over = 1'b0;
        for (int i = 0; i < AXES; i++) begin
            absd[i] = r6_diff[i][DIFF_W-1] ? ABS_W'(-r6_diff[i]) : ABS_W'(r6_diff[i]);
            absl[i] = r6_loc[i][LOC_W-1] ? ABS_W'(-r6_loc[i]) : ABS_W'(r6_loc[i]);
            if (absl[i] > ABS_W'(w_ext[i])) begin
                gap[i] = absl[i] - ABS_W'(w_ext[i]);
                over   = 1'b1;
            end else begin
                gap[i] = '0;
            end
            pen[i] = w_ext[i] - absl[i][COORD_W-1:0];
        end
        mp = (pen[1] < pen[0]) ? pen[1] : pen[0];
        if (pen[2] < mp) begin
            mp = pen[2];
        end
        n7_side.in_box = !over;
        n7_side.neg_mp = -$signed(NMP_W'(mp));
        n7_side.vp     = $signed(VP_W'(absl[2])) - $signed(VP_W'(w_ext[2]));
        unique case (r_kind)
            SHAPE_BOX: begin
                n7_mag = gap;
            end
            SHAPE_CYLINDER: begin
                n7_mag[0] = absl[0];
                n7_mag[1] = absl[1];
                n7_mag[2] = '0;
            end
            SHAPE_SPHERE, SHAPE_OTHER: begin
                n7_mag = absd;
            end
        endcase
    end

    // stage 8: squares
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            n8_sq[i] = r7_mag[i] * r7_mag[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_vt   <= n1_vt;
            r1_p    <= w_pt;
            r2_diff <= n2_diff;
            r3_a    <= n3_a;
            r3_b    <= n3_b;
            r3_diff <= r2_diff;
            r4_t    <= n4_t;
            r4_diff <= r3_diff;
            r5_w    <= n5_w;
            r5_a    <= n5_a;
            r5_b    <= n5_b;
            r5_diff <= r4_diff;
            r6_loc  <= n6_loc;
            r6_diff <= r5_diff;
            r7_mag  <= n7_mag;
            r7_side <= n7_side;
            r8_sq   <= n8_sq;
            r8_side <= r7_side;
            r9_sum  <= SQ_IN_W'(r8_sq[0]) + SQ_IN_W'(r8_sq[1]) + SQ_IN_W'(r8_sq[2]);
            r9_side <= r8_side;
            r_sa[0] <= r9_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_sa[k] <= r_sa[k-1];
            end
            r10_sb  <= n10_sb;
            r10_h   <= n10_h;
            r10_vv  <= n10_vv;
            r11_hsq <= SQ_IN_W'(r10_h * r10_h);
            r11_vsq <= SQ_IN_W'(r10_vv * r10_vv);
            r11_sb  <= r10_sb;
            r12_sum <= r11_hsq + r11_vsq;
            r12_sb  <= r11_sb;
            r_sbd[0] <= r12_sb;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_sbd[k] <= r_sbd[k-1];
            end
            r13_d   <= n13_d;
        end
    end

    osd_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r9_sum),
        .o_root (w_root_a)
    );

    // after the first root: finish the shape or set up the cylinder corner
    always_comb begin
        t_side_a               sa;
        logic signed [D_W-1:0] ra, hp, vp;
        sa = r_sa[SQ_LAT-1];
        ra = $signed(D_W'(w_root_a));
        hp = ra - $signed(D_W'(w_ext[0]));
        vp = D_W'($signed(sa.vp));
        n10_sb.need2 = 1'b0;
        n10_sb.d_pre = hp;
        n10_h  = '0;
        n10_vv = '0;
        unique case (r_kind)
            SHAPE_SPHERE: begin
                n10_sb.d_pre = hp;
            end
            SHAPE_BOX: begin
                n10_sb.d_pre = sa.in_box ? D_W'($signed(sa.neg_mp)) : ra;
            end
            SHAPE_CYLINDER: begin
                priority if (hp < 0 && vp < 0) begin
                    n10_sb.d_pre = (hp > vp) ? hp : vp;
                end else if (hp < 0) begin
                    n10_sb.d_pre = vp;
                end else if (vp < 0) begin
                    n10_sb.d_pre = hp;
                end else begin
                    n10_sb.need2 = 1'b1;
                    n10_h  = hp[VP_W-1:0];
                    n10_vv = vp[VP_W-1:0];
                end
            end
            SHAPE_OTHER: begin
                n10_sb.d_pre = ra - $signed(D_W'(w_extmax));
            end
        endcase
    end

    osd_sqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  (r12_sum),
        .o_root (w_root_b)
    );

    // margin and output saturation
    always_comb begin
        t_side_b                sb;
        logic signed [D_W-1:0]  d;
        logic signed [DM_W-1:0] dm;
        sb = r_sbd[SQ_LAT-1];
        d  = sb.need2 ? $signed(D_W'(w_root_b)) : $signed(sb.d_pre);
        dm = DM_W'(d) - $signed(DM_W'(r_margin));
        if (dm > DM_W'(OUT_MAX)) begin
            n13_d.signed_distance = OUT_W'(OUT_MAX);
        end else if (dm < DM_W'(OUT_MIN)) begin
            n13_d.signed_distance = OUT_W'(OUT_MIN);
        end else begin
            n13_d.signed_distance = OUT_W'(dm);
        end
        n13_d.inside_flag = dm[DM_W-1];
    end

    // output register with one skid entry; skid full freezes the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_out_stall) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || !i_out_stall) begin
            r_ov <= r13_v;
        end else if (r13_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_out_stall) begin
                r_od <= r_sd;
            end
        end else if (!r_ov || !i_out_stall) begin
            r_od <= r13_d;
        end else begin
            r_sd <= r13_d;
        end
    end

    `OSD_ASSERT_SAME(a_skid_has_out, r_sv, r_ov, "skid entry full with output empty")
    `OSD_ASSERT_SAME(a_flag_sign, r_ov, r_od.inside_flag == w_od_sign, "flag disagrees with sign")
    `OSD_ASSERT_NEXT(a_skid_fill, r13_v && r_ov && i_out_stall && !r_sv, r_sv, "item lost")
    `OSD_ASSERT_NEXT(a_skid_drain, r_sv && !i_out_stall, r_ov && !r_sv, "skid entry not moved")

endmodule

`default_nettype wire

/* tb/obstacle_signed_distance_unit_tb.sv */
// Self-checking testbench for the obstacle signed distance unit.
`default_nettype none

module obstacle_signed_distance_unit_tb;
    import osd_pkg::*;

    localparam int LATENCY = 76;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    obstacle_signed_distance_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the obstacle registers
    t_shape         sh_kind;
    logic [59:0]    sh_center;
    logic [59:0]    sh_extents;
    logic [63:0]    sh_rot;
    logic [15:0]    sh_margin;
    logic           sh_moving;
    logic [59:0]    sh_vel;

    t_out_item      dist_queue[$];
    int             error_count;
    int             send_idle_pct;
    int             recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("obstacle_signed_distance_unit regression: fail");
        $finish;
    end

    function automatic longint round_shift(longint x, int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_sqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s > r) r = r + 1;
        return longint'(r);
    endfunction

    function automatic longint norm3(longint a, longint b, longint c);
        longint unsigned s;
        s = longint'(a * a) + longint'(b * b) + longint'(c * c);
        return round_sqrt(s);
    endfunction

    // rotate a world offset into the obstacle frame by the inverse quaternion
    function automatic void to_local(input longint v[3], output longint o[3]);
        longint w, qx, qy, qz;
        longint t[3];
        longint r[3];
        w  = longint'($signed(sh_rot[15:0]));
        qx = -longint'($signed(sh_rot[31:16]));
        qy = -longint'($signed(sh_rot[47:32]));
        qz = -longint'($signed(sh_rot[63:48]));
        t[0] = round_shift(2 * (qy * v[2] - qz * v[1]), 14);
        t[1] = round_shift(2 * (qz * v[0] - qx * v[2]), 14);
        t[2] = round_shift(2 * (qx * v[1] - qy * v[0]), 14);
        r[0] = w * t[0] + (qy * t[2] - qz * t[1]);
        r[1] = w * t[1] + (qz * t[0] - qx * t[2]);
        r[2] = w * t[2] + (qx * t[1] - qy * t[0]);
        for (int i = 0; i < 3; i++)
            o[i] = clamp(v[i] + round_shift(r[i], 14), -268435455, 268435455);
    endfunction

    function automatic t_out_item predict_distance(t_in_item it);
        longint diff[3], loc[3], ext[3], gap[3], pt[3];
        longint c, d, mp, p, hp, vp, mx;
        logic in_box;
        t_out_item res;
        pt[0] = longint'(it.point_x);
        pt[1] = longint'(it.point_y);
        pt[2] = longint'(it.point_z);
        for (int i = 0; i < 3; i++) begin
            c = longint'($signed(sh_center[20*i +: 20]));
            if (sh_moving)
                c = c + round_shift(longint'($signed(sh_vel[20*i +: 20]))
                                    * longint'(it.time_offset), 10);
            diff[i] = pt[i] - c;
            ext[i]  = longint'(sh_extents[20*i +: 20]);
        end
        case (sh_kind)
            SHAPE_SPHERE: d = norm3(diff[0], diff[1], diff[2]) - ext[0];
            SHAPE_BOX: begin
                to_local(diff, loc);
                in_box = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    gap[i] = loc[i] - clamp(loc[i], -ext[i], ext[i]);
                    if (gap[i] != 0) in_box = 1'b0;
                end
                if (in_box) begin
                    mp = ext[0] - mag(loc[0]);
                    for (int i = 1; i < 3; i++) begin
                        p = ext[i] - mag(loc[i]);
                        if (p < mp) mp = p;
                    end
                    d = -mp;
                end else begin
                    d = norm3(gap[0], gap[1], gap[2]);
                end
            end
            SHAPE_CYLINDER: begin
                to_local(diff, loc);
                hp = round_sqrt(loc[0] * loc[0] + loc[1] * loc[1]) - ext[0];
                vp = mag(loc[2]) - ext[2];
                if (hp < 0 && vp < 0) d = hp > vp ? hp : vp;
                else if (hp < 0) d = vp;
                else if (vp < 0) d = hp;
                else d = round_sqrt(hp * hp + vp * vp);
            end
            default: begin
                mx = ext[0];
                if (ext[1] > mx) mx = ext[1];
                if (ext[2] > mx) mx = ext[2];
                d = norm3(diff[0], diff[1], diff[2]) - mx;
            end
        endcase
        d = clamp(d - longint'(sh_margin), -8388608, 8388607);
        res.signed_distance = d[23:0];
        res.inside_flag     = d < 0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KIND:     sh_kind    = t_shape'(val[1:0]);
            CFG_CENTER:   sh_center  = val[59:0];
            CFG_EXTENTS:  sh_extents = val[59:0];
            CFG_ROTATION: sh_rot     = val;
            CFG_MARGIN:   sh_margin  = val[15:0];
            CFG_MOVING:   sh_moving  = val[0];
            default:      sh_vel     = val[59:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_point(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        dist_queue.push_back(predict_distance(it));
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (dist_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // receiver side: random stall, compare every accepted item
    always @(negedge i_clk) begin
        i_out_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dist_queue.size() == 0) begin
                report_mismatch("unexpected item", o_out_data.signed_distance, 0);
            end else begin
                want = dist_queue.pop_front();
                if (o_out_data.signed_distance !== want.signed_distance)
                    report_mismatch("signed_distance", o_out_data.signed_distance,
                                    want.signed_distance);
                if (o_out_data.inside_flag !== want.inside_flag)
                    report_mismatch("inside_flag", o_out_data.inside_flag,
                                    want.inside_flag);
            end
        end
    end

    function automatic logic [59:0] rand_vec(int span);
        logic [59:0] v;
        for (int i = 0; i < 3; i++)
            v[20*i +: 20] = (span == 0) ? 20'($urandom)
                          : 20'($signed($urandom_range(2 * span)) - span);
        return v;
    endfunction

    function automatic logic [59:0] rand_ext(int span);
        logic [59:0] v;
        for (int i = 0; i < 3; i++)
            v[20*i +: 20] = (span == 0) ? 20'($urandom) : 20'($urandom_range(span));
        return v;
    endfunction

    function automatic logic [63:0] rand_quat();
        logic [63:0] q;
        // mostly near-unit rotations, sometimes raw bits
        if ($urandom_range(3) == 0) return {$urandom, $urandom};
        case ($urandom_range(3))
            0: q = {16'sd0, 16'sd0, 16'sd11585, 16'sd11585};
            1: q = {16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
            2: q = {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
            default: q = {16'sd0, 16'sd16384, 16'sd0, 16'sd0};
        endcase
        return q;
    endfunction

    function automatic t_in_item rand_point(int span);
        t_in_item it;
        if (span == 0) begin
            it.point_x = 20'($urandom);
            it.point_y = 20'($urandom);
            it.point_z = 20'($urandom);
        end else begin
            it.point_x = 20'($signed($urandom_range(2 * span)) - span);
            it.point_y = 20'($signed($urandom_range(2 * span)) - span);
            it.point_z = 20'($signed($urandom_range(2 * span)) - span);
        end
        it.time_offset = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2048));
        return it;
    endfunction

    typedef struct {
        logic [19:0] px, py, pz;
        logic [15:0] tof;
        logic        known;
        logic [23:0] exp_dist;
    } t_point_row;

    // reset registers: sphere of zero radius at the origin
    t_point_row point_rows[] = '{
        '{20'd0, 20'd0, 20'd0, 16'd0, 1'b1, 24'd0},
        '{20'd3, 20'd4, 20'd0, 16'd0, 1'b1, 24'd5},
        '{20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF, 1'b1, 24'd908092},
        '{20'h80000, 20'h80000, 20'h80000, 16'd0, 1'b1, 24'd908093},
        '{20'h80000, 20'h7FFFF, 20'd0, 16'h8000, 1'b0, 24'd0},
        '{20'd100, 20'hFFF9C, 20'd7, 16'd1, 1'b0, 24'd0}
    };

    initial begin
        t_in_item it;
        int total;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sh_kind = SHAPE_SPHERE;
        sh_center = '0; sh_extents = '0; sh_rot = 64'd16384;
        sh_margin = '0; sh_moving = 1'b0; sh_vel = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (point_rows[r]) begin
            it.point_x = point_rows[r].px;
            it.point_y = point_rows[r].py;
            it.point_z = point_rows[r].pz;
            it.time_offset = point_rows[r].tof;
            send_point(it);
            if (point_rows[r].known && dist_queue[$].signed_distance != point_rows[r].exp_dist)
                report_mismatch("table row", dist_queue[$].signed_distance,
                                point_rows[r].exp_dist);
        end
        drain_results();

        // every shape at extreme settings, margin at both ends
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_KIND, 64'(k));
            write_reg(CFG_EXTENTS,
                      64'(k[0] ? 60'hFFFFF_FFFFF_FFFFF : {20'd40, 20'd30, 20'd50}));
            write_reg(CFG_MARGIN, k[1] ? 64'hFFFF : 64'd0);
            write_reg(CFG_MOVING, 64'(k[0]));
            write_reg(CFG_VELOCITY,
                      64'(k[1] ? 60'h7FFFF_80000_7FFFF : 60'h80000_7FFFF_80000));
            write_reg(CFG_ROTATION, k == 2 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_7FFF_8000_7FFF);
            write_reg(CFG_CENTER,
                      64'(k[0] ? 60'h80000_80000_80000 : 60'h7FFFF_7FFFF_7FFFF));
            for (int j = 0; j < 4; j++) begin
                it = rand_point(0);
                if (j == 0) it = '{20'sd0, 20'sd0, 20'sd0, 16'd0};
                if (j == 1) it.time_offset = 16'hFFFF;
                send_point(it);
            end
            drain_results();
        end

        total = 0;
        for (int ph = 0; ph < 24; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_reg(CFG_KIND, 64'($urandom_range(3)));
            write_reg(CFG_CENTER, 64'(rand_vec(ph % 5 == 4 ? 0 : 2000)));
            write_reg(CFG_EXTENTS, 64'(rand_ext(ph % 6 == 5 ? 0 : 800)));
            write_reg(CFG_ROTATION, rand_quat());
            write_reg(CFG_MARGIN, ph % 3 == 0 ? 64'($urandom) & 64'hFFFF : 64'($urandom_range(64)));
            write_reg(CFG_MOVING, 64'($urandom_range(1)));
            write_reg(CFG_VELOCITY, 64'(rand_vec(ph % 7 == 6 ? 0 : 500)));
            for (int n = 0; n < 75; n++) begin
                // most points close to the obstacle so every branch is reached
                send_point(rand_point($urandom_range(4) == 0 ? 0 : 2500));
                total++;
            end
            drain_results();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();

        if (error_count == 0) begin
            $display("obstacle_signed_distance_unit regression: pass");
        end else begin
            $display("obstacle_signed_distance_unit regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
